### src/bqlp_pkg.sv
// Shared types, constants and datapath op codes for the biquad low-pass filter.
`default_nettype none

package bqlp_pkg;

    // Default widths
    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_COEF_FRAC_BITS  = 14;
    localparam int DEF_DELAY_FRAC_BITS = 8;

    // Register index port
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS  = 3'd5;

    // Datapath operations, one per cycle
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,        // take sample, acc = x - a1*d1 (+ round)
        OP_MSUB_A2,     // acc -= a2*d2
        OP_W0,          // latch w0 with guard, acc = round + b1*d1
        OP_MAC_B2,      // acc += b2*d2
        OP_MAC_B0,      // acc += b0*w0
        OP_FINISH       // write result (saturated, or raw sample on bypass), shift delay line unless bypass
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic bypass;       // bypass register
        logic out_free;     // result register can take a word this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

### src/biquad_lowpass_filter.sv
// Top level of the second-order direct form II low-pass biquad.
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ----------------------------
//  input     in         i_in_valid / o_in_ready    i_sample_in
//  output    out        o_out_valid / i_out_ready  o_filtered, o_guard_hit
//  config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// Sequence: a filtered word goes through five products sharing one multiplier
//   (x-a1*d1, a2*d2, b1*d1, b2*d2, b0*w0, one per cycle, the first in the accepting
//   cycle) and then a saturate-and-write step into the result register; a new word
//   is not taken until the last one is written. A bypass word skips the products and
//   goes straight to the write step.
// Reset: synchronous, active low; coefficients clear, bypass sets, delay line
//   clears. Ready rises the cycle after reset is released.
// Stalls: the result register holds a word while i_out_ready is low; the next word
//   is still accepted and worked on, and waits in its final cycle until the
//   result register is free.
`default_nettype none

module biquad_lowpass_filter
    import bqlp_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS,
    parameter int DELAY_FRAC_BITS = DEF_DELAY_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // register write port
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [COEF_FRAC_BITS+3:0]     i_cfg_data,
    // sample in
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    // result out
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered,
    output logic                               o_guard_hit
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    // sequencer: walks one word through the MAC steps
    bqlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    // datapath: registers, delay line, shared multiplier and accumulator
    bqlp_dpath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS),
        .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_in (i_sample_in),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_filtered  (o_filtered),
        .o_guard_hit (o_guard_hit),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire

### src/bqlp_ctrl.sv
// Sequencer for the biquad filter: steps the shared multiply-accumulate datapath.
`default_nettype none

module bqlp_ctrl
    import bqlp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MA2,
        S_W0,
        S_MB2,
        S_MB0,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   s_accept;

    assign s_accept   = (r_state == S_IDLE) && r_in_ready && i_in_valid;
    assign o_in_ready = r_in_ready;

    always_comb begin
        unique case (r_state)
            S_IDLE:  o_cmd.op = s_accept ? OP_LOAD : OP_IDLE;
            S_MA2:   o_cmd.op = OP_MSUB_A2;
            S_W0:    o_cmd.op = OP_W0;
            S_MB2:   o_cmd.op = OP_MAC_B2;
            S_MB0:   o_cmd.op = OP_MAC_B0;
            S_FIN:   o_cmd.op = i_sts.out_free ? OP_FINISH : OP_IDLE;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_in_ready <= 1'b0;
                        // bypass words skip the arithmetic
                        r_state    <= i_sts.bypass ? S_FIN : S_MA2;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_MA2: r_state <= S_W0;
                S_W0:  r_state <= S_MB2;
                S_MB2: r_state <= S_MB0;
                S_MB0: r_state <= S_FIN;
                S_FIN: begin
                    if (i_sts.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/bqlp_dpath.sv
// Biquad datapath: coefficient registers, delay line, one shared MAC, result register.
`default_nettype none

module bqlp_dpath
    import bqlp_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS,
    parameter int DELAY_FRAC_BITS = DEF_DELAY_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [COEF_FRAC_BITS+3:0]     i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_sts                            o_sts,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered,
    output logic                               o_guard_hit,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready
);

    localparam int CB = COEF_FRAC_BITS + 4;
    localparam int DB = SAMPLE_BITS + DELAY_FRAC_BITS;
    localparam int PB = CB + DB;
    localparam int AB = PB + 2;
    localparam int PF = DELAY_FRAC_BITS + COEF_FRAC_BITS;

    localparam logic [AB-1:0] RND_CF = {{(AB-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic [AB-1:0] RND_PF = {{(AB-1){1'b0}}, 1'b1} << (PF - 1);

    logic signed [CB-1:0]          r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;
    logic                          r_bypass;
    logic signed [DB-1:0]          r_d1, r_d2, r_w0;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [AB-1:0]          r_acc;
    logic                          r_guard, r_byp_item;
    logic signed [SAMPLE_BITS-1:0] r_filtered;
    logic                          r_guard_hit, r_out_valid;

    logic signed [CB-1:0]          s_mul_c;
    logic signed [DB-1:0]          s_mul_d;
    logic signed [PB-1:0]          s_prod;
    logic signed [AB-1:0]          s_prod_ext, s_x_ext;
    logic                          s_w0_ok, s_y_ok;
    logic signed [DB-1:0]          s_w0;
    logic signed [SAMPLE_BITS-1:0] s_y;

    // Operand select for the shared multiplier
    always_comb begin
        unique case (i_cmd.op)
            OP_MSUB_A2: begin s_mul_c = r_coef_a2; s_mul_d = r_d2; end
            OP_W0:      begin s_mul_c = r_coef_b1; s_mul_d = r_d1; end
            OP_MAC_B2:  begin s_mul_c = r_coef_b2; s_mul_d = r_d2; end
            OP_MAC_B0:  begin s_mul_c = r_coef_b0; s_mul_d = r_w0; end
            default:    begin s_mul_c = r_coef_a1; s_mul_d = r_d1; end
        endcase
    end

    assign s_prod     = s_mul_c * s_mul_d;
    assign s_prod_ext = AB'(s_prod);
    assign s_x_ext    = AB'(i_sample_in) <<< PF;

    // w0 guard: rounded intermediate must fit the delay width
    assign s_w0_ok = (&r_acc[AB-1:COEF_FRAC_BITS+DB-1]) | ~(|r_acc[AB-1:COEF_FRAC_BITS+DB-1]);
    assign s_w0    = s_w0_ok ? r_acc[COEF_FRAC_BITS+DB-1:COEF_FRAC_BITS]
                             : (DB'(r_x) <<< DELAY_FRAC_BITS);

    // output saturation
    assign s_y_ok = (&r_acc[AB-1:PF+SAMPLE_BITS-1]) | ~(|r_acc[AB-1:PF+SAMPLE_BITS-1]);
    assign s_y    = s_y_ok ? r_acc[PF+SAMPLE_BITS-1:PF]
                           : {r_acc[AB-1], {(SAMPLE_BITS-1){~r_acc[AB-1]}}};

    // config, delay line and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0   <= '0;
            r_coef_b1   <= '0;
            r_coef_b2   <= '0;
            r_coef_a1   <= '0;
            r_coef_a2   <= '0;
            r_bypass    <= 1'b1;
            r_d1        <= '0;
            r_d2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_COEF_B0: r_coef_b0 <= i_cfg_data;
                    REG_COEF_B1: r_coef_b1 <= i_cfg_data;
                    REG_COEF_B2: r_coef_b2 <= i_cfg_data;
                    REG_COEF_A1: r_coef_a1 <= i_cfg_data;
                    REG_COEF_A2: r_coef_a2 <= i_cfg_data;
                    REG_BYPASS:  r_bypass  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_FINISH) begin
                r_out_valid <= 1'b1;
                if (!r_byp_item) begin
                    r_d2 <= r_d1;
                    r_d1 <= r_w0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // accumulator and working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x        <= i_sample_in;
                r_byp_item <= r_bypass;
                r_acc      <= s_x_ext + RND_CF - s_prod_ext;
            end
            OP_MSUB_A2: r_acc <= r_acc - s_prod_ext;
            OP_W0: begin
                r_w0    <= s_w0;
                r_guard <= ~s_w0_ok;
                r_acc   <= RND_PF + s_prod_ext;
            end
            OP_MAC_B2, OP_MAC_B0: r_acc <= r_acc + s_prod_ext;
            OP_FINISH: begin
                r_filtered  <= r_byp_item ? r_x : s_y;
                r_guard_hit <= r_byp_item ? 1'b0 : r_guard;
            end
            default: ;
        endcase
    end

    assign o_sts.bypass   = r_bypass;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_filtered     = r_filtered;
    assign o_guard_hit    = r_guard_hit;
    assign o_out_valid    = r_out_valid;

    // a result is only written into a free output register
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FINISH) |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken word");

    // bypass leaves the delay line alone
    a_bypass_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FINISH && r_byp_item) |=> ($stable(r_d1) && $stable(r_d2)))
        else $error("delay line moved on a bypass word");

    // bypass word comes out unchanged, with no guard flag
    a_bypass_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FINISH && r_byp_item) |=>
            (o_out_valid && !o_guard_hit && o_filtered == $past(r_x)))
        else $error("bypass word altered");

    // filtered word shifts the delay line by one
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FINISH && !r_byp_item) |=>
            (r_d2 == $past(r_d1) && r_d1 == $past(r_w0)))
        else $error("delay line shift wrong");

endmodule

`default_nettype wire
